@@ rtl/srcc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the sensor response CRC checker.
package srcc_pkg;

  localparam int unsigned RxByteW  = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned TempW    = 15;
  localparam int unsigned HumW     = 14;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PosW     = 3;
  localparam int unsigned OutDataW = 64;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [31:0] TempSpan   = 32'd17500;
  localparam logic [31:0] HumSpan    = 32'd10000;
  localparam logic [TempW-1:0] TempOffset = 15'd4500;
  localparam logic [HumW-1:0]  HumMax     = 14'd10000;
  localparam logic [WordW:0]   FullScale  = 17'd65535;

  // Byte positions inside a measurement frame.
  localparam logic [PosW-1:0] PosCheck1 = 3'd2;
  localparam logic [PosW-1:0] PosGroup2 = 3'd3;
  localparam logic [PosW-1:0] PosLast   = 3'd5;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_FIRST = 2'd1,
    STATUS_BAD_SECOND = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [HumW-1:0]  humidity_centi;
    logic [TempW-1:0] temperature_centi;
    logic [WordW-1:0] second_word;
    logic [WordW-1:0] first_word;
    frame_status_t    frame_status;
  } result_t;

  // CRC-8, MSB first, one byte folded in.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^32 / 2: x = q0*65535 + (q0 + lo), one correction step.
  function automatic logic [WordW-1:0] div_full_scale(input logic [31:0] x);
    logic [WordW-1:0] q0;
    logic [WordW:0]   r;
    q0 = x[31:16];
    r  = {1'b0, x[15:0]} + {1'b0, q0};
    return q0 + WordW'(r >= FullScale);
  endfunction

endpackage

@@ rtl/sensor_response_crc_checker.sv @@
// Top level of the sensor response CRC checker: byte intake, CRC check and scaling.
module sensor_response_crc_checker (
  input  logic        clk,
  input  logic        rst,
  // Received bytes.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] frame_start
  // Frame results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [srcc_pkg::OutDataW-1:0] m_tdata,
  // [1:0] frame_status, [17:2] first_word, [33:18] second_word,
  // [48:34] temperature_centi, [62:49] humidity_centi, [63] zero
  // Frame kind register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // frame_kind: 0 six-byte measurement, 1 three-byte status
);
  // This block takes the byte stream that a humidity/temperature sensor returns, one byte per
  // transfer, and checks each pair of data bytes against the CRC-8 byte that follows it
  // (polynomial 0x31, start value 0xFF, MSB first). A measurement frame is six bytes and a
  // status frame three, as chosen by the frame kind register; tuser marks the first byte of a
  // frame and restarts the byte count, and without it the count simply runs on from frame to
  // frame. After the last byte one result transfer carries the raw words, a status code (the
  // first CRC error wins) and the temperature and humidity scaled to hundredths. Words with a
  // bad CRC are still reported as received. A byte is registered at the input, and once the output
  // is free the CRC update, frame bookkeeping and the scaling (one 16x15 multiply and a
  // reciprocal correction per value) land in the result register.
  // A new byte is accepted in every cycle while results are taken; the input register lets one
  // byte enter while a finished result still waits. The frame kind register may only be
  // written while no byte is in flight and no result is pending.
  import srcc_pkg::*;

  // Configuration.
  logic frame_kind;

  // Input register.
  logic               in_valid;
  logic [RxByteW-1:0] in_byte;
  logic               in_start;

  // Frame state.
  logic [PosW-1:0]    byte_position;
  logic [7:0]         running_check;
  logic [7:0]         word_high_byte;
  logic [WordW-1:0]   held_first_word;
  logic [WordW-1:0]   held_second_word;
  logic               first_check_good;

  // Result register.
  result_t result;

  // Next values.
  logic [PosW-1:0]    byte_position_next;
  logic [7:0]         running_check_next;
  logic [7:0]         word_high_byte_next;
  logic [WordW-1:0]   held_first_word_next;
  logic [WordW-1:0]   held_second_word_next;
  logic               first_check_good_next;
  logic               result_fire;
  result_t            result_next;

  logic               out_free;
  logic               advance;
  logic [PosW-1:0]    pos;
  logic               good_first_now;
  logic [7:0]         crc_from_init;
  logic [7:0]         crc_from_run;
  logic [WordW-1:0]   word_now;
  logic [31:0]        temp_prod;
  logic [31:0]        hum_prod;
  logic [WordW-1:0]   temp_q;
  logic [WordW-1:0]   hum_q;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  assign crc_from_init = crc_feed(CrcInit, in_byte);
  assign crc_from_run  = crc_feed(running_check, in_byte);
  assign word_now      = {word_high_byte, in_byte};

  // Scaling of the held raw words; both are stable by the time a frame ends.
  assign temp_prod = 32'(held_first_word) * TempSpan;
  assign hum_prod  = 32'(held_second_word) * HumSpan;
  assign temp_q    = div_full_scale(temp_prod);
  assign hum_q     = div_full_scale(hum_prod);

  always_comb begin
    byte_position_next    = byte_position;
    running_check_next    = running_check;
    word_high_byte_next   = word_high_byte;
    held_first_word_next  = held_first_word;
    held_second_word_next = held_second_word;
    first_check_good_next = first_check_good && !in_start;
    result_fire           = 1'b0;
    result_next.frame_status      = STATUS_OK;
    result_next.first_word        = held_first_word;
    result_next.second_word       = '0;
    result_next.temperature_centi = '0;
    result_next.humidity_centi    = '0;

    // A start mark restarts the count; a position past the frame wraps to its first byte,
    // and in a status frame a second-group position folds onto the first group.
    pos = in_start ? '0 : byte_position;
    if (pos > PosLast) begin
      pos = '0;
    end
    if (frame_kind && pos >= PosGroup2) begin
      pos = pos - PosGroup2;
    end
    good_first_now = (running_check == in_byte);

    case (pos)
      3'd0, 3'd3: begin
        running_check_next  = crc_from_init;
        word_high_byte_next = in_byte;
        byte_position_next  = pos + 3'd1;
      end
      3'd1: begin
        running_check_next   = crc_from_run;
        held_first_word_next = word_now;
        byte_position_next   = pos + 3'd1;
      end
      3'd4: begin
        running_check_next    = crc_from_run;
        held_second_word_next = word_now;
        byte_position_next    = pos + 3'd1;
      end
      PosCheck1: begin
        first_check_good_next = good_first_now;
        if (!frame_kind) begin
          byte_position_next = pos + 3'd1;
        end else begin
          result_fire              = 1'b1;
          result_next.frame_status = good_first_now ? STATUS_OK : STATUS_BAD_FIRST;
          byte_position_next       = '0;
          running_check_next       = CrcInit;
        end
      end
      default: begin
        // Check byte of the second word: the frame ends here.
        result_fire = 1'b1;
        if (!first_check_good_next) begin
          result_next.frame_status = STATUS_BAD_FIRST;
        end else if (!good_first_now) begin
          result_next.frame_status = STATUS_BAD_SECOND;
        end else begin
          result_next.frame_status = STATUS_OK;
        end
        result_next.second_word       = held_second_word;
        result_next.temperature_centi = temp_q[TempW-1:0] - TempOffset;
        result_next.humidity_centi    = (hum_q > WordW'(HumMax)) ? HumMax : hum_q[HumW-1:0];
        byte_position_next = '0;
        running_check_next = CrcInit;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind       <= 1'b0;
      in_valid         <= 1'b0;
      m_tvalid         <= 1'b0;
      byte_position    <= '0;
      running_check    <= CrcInit;
      word_high_byte   <= '0;
      held_first_word  <= '0;
      held_second_word <= '0;
      first_check_good <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_kind <= cfg_data;
      end

      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_tdata;
        in_start <= s_tuser;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      // A new result replaces one that is taken in the same cycle.
      if (advance && result_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (advance) begin
        byte_position    <= byte_position_next;
        running_check    <= running_check_next;
        word_high_byte   <= word_high_byte_next;
        held_first_word  <= held_first_word_next;
        held_second_word <= held_second_word_next;
        first_check_good <= first_check_good_next;
        if (result_fire) begin
          result <= result_next;
        end
      end
    end
  end

  assign m_tdata = {1'b0, result};

`ifndef NO_ASSERTIONS
  // The input side only stalls when a byte waits behind a result that is not being taken.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  // The byte count never leaves the six positions of a frame.
  assert property (@(posedge clk) disable iff (rst) byte_position <= PosLast)
    else $error("byte position out of range");

  // Scaled values stay inside the sensor's range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(result.temperature_centi) >= -15'sd4500 &&
                  $signed(result.temperature_centi) <= 15'sd13000 &&
                  result.humidity_centi <= HumMax))
    else $error("scaled value out of range");

  // A result that is not taken stays in place.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(result)))
    else $error("pending result changed");
`endif

endmodule

@@ tb/frame_result_checker.sv @@
// Frame decoder model and result comparison for the sensor response CRC checker bench.
module frame_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  input  logic                          s_tuser,   // [0] frame_start
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [srcc_pkg::OutDataW-1:0] m_tdata,   // result_t in [62:0]
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,
  output int                            fail_count,
  output int                            frames_checked,
  output int                            frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import srcc_pkg::*;

  // Decoder state as the block should hold it.
  logic        status_frames;
  logic [2:0]  byte_slot;
  logic [7:0]  crc_acc;
  logic [7:0]  high_byte;
  logic [15:0] raw_temp_word;
  logic [15:0] raw_hum_word;
  logic        temp_word_good;

  result_t expected_frames[$];

  // Serial CRC-8, one data bit per shift, MSB first.
  function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  initial begin
    fail_count     = 0;
    frames_checked = 0;
    frames_pending = 0;
  end

  always @(posedge clk) begin : track_frames
    logic [2:0]  pos;
    logic        second_group;
    logic [15:0] word;
    logic [31:0] temp_scaled;
    logic [31:0] hum_scaled;
    result_t     want;
    result_t     got;
    if (rst) begin
      status_frames  = 1'b0;
      byte_slot      = '0;
      crc_acc        = CrcInit;
      high_byte      = '0;
      raw_temp_word  = '0;
      raw_hum_word   = '0;
      temp_word_good = 1'b0;
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        status_frames = cfg_data;
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          byte_slot      = '0;
          temp_word_good = 1'b0;
        end
        pos = (byte_slot > PosLast) ? 3'd0 : byte_slot;
        // A status frame folds a second-group position back onto the first group.
        if (status_frames && pos >= PosGroup2) begin
          pos = pos - PosGroup2;
        end
        second_group = (pos >= PosGroup2);

        if (pos == 3'd0 || pos == PosGroup2) begin
          crc_acc   = crc8_shift_in(CrcInit, s_tdata);
          high_byte = s_tdata;
          byte_slot = pos + 3'd1;
        end else if (pos != PosCheck1 && pos != PosLast) begin
          crc_acc = crc8_shift_in(crc_acc, s_tdata);
          word    = {high_byte, s_tdata};
          if (second_group) begin
            raw_hum_word = word;
          end else begin
            raw_temp_word = word;
          end
          byte_slot = pos + 3'd1;
        end else if (!second_group) begin
          temp_word_good = (crc_acc == s_tdata);
          if (status_frames) begin
            want                   = '0;
            want.frame_status      = temp_word_good ? STATUS_OK : STATUS_BAD_FIRST;
            want.first_word        = raw_temp_word;
            expected_frames.push_back(want);
            byte_slot = '0;
            crc_acc   = CrcInit;
          end else begin
            byte_slot = pos + 3'd1;
          end
        end else begin
          temp_scaled = (TempSpan * {16'd0, raw_temp_word}) / 32'd65535;
          hum_scaled  = (HumSpan * {16'd0, raw_hum_word}) / 32'd65535;
          if (hum_scaled > HumSpan) begin
            hum_scaled = HumSpan;
          end
          if (!temp_word_good) begin
            want.frame_status = STATUS_BAD_FIRST;
          end else if (crc_acc != s_tdata) begin
            want.frame_status = STATUS_BAD_SECOND;
          end else begin
            want.frame_status = STATUS_OK;
          end
          want.first_word        = raw_temp_word;
          want.second_word       = raw_hum_word;
          want.temperature_centi = temp_scaled[TempW-1:0] - TempOffset;
          want.humidity_centi    = hum_scaled[HumW-1:0];
          expected_frames.push_back(want);
          byte_slot = '0;
          crc_acc   = CrcInit;
        end
      end

      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: frame result %h arrived with none expected", $time, m_tdata);
          end
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (got.frame_status !== want.frame_status || got.first_word !== want.first_word ||
              got.second_word !== want.second_word ||
              got.temperature_centi !== want.temperature_centi ||
              got.humidity_centi !== want.humidity_centi) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: expected status %0d words %h %h temp %0d hum %0d", $time,
                       want.frame_status, want.first_word, want.second_word,
                       $signed(want.temperature_centi), want.humidity_centi);
              $display("%0t:      got status %0d words %h %h temp %0d hum %0d", $time,
                       got.frame_status, got.first_word, got.second_word,
                       $signed(got.temperature_centi), got.humidity_centi);
            end
          end
        end
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

@@ tb/tb_sensor_response_crc_checker.sv @@
// Top of the sensor response CRC checker bench: clock, reset, byte and result traffic, verdict.
module tb_sensor_response_crc_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import srcc_pkg::*;

  // Cycles allowed for the block to settle after the last expected frame result.
  localparam int DrainCycles = 24;
  // Bytes per random phase before the frame kind is changed again.
  localparam int PhaseBytes  = 90;
  localparam int PhaseCount  = 6;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data  = 1'b0;

  int fail_count;
  int frames_checked;
  int frames_pending;
  int bytes_sent = 0;
  int kind_writes = 0;

  // When set, the side concerned runs back to back with no idle cycles.
  logic src_burst  = 1'b0;
  logic sink_burst = 1'b0;

  always #4 clk = ~clk;

  sensor_response_crc_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  frame_result_checker i_chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .frames_checked (frames_checked),
    .frames_pending (frames_pending)
  );

  // CRC-8 of one 16-bit sensor word, used to build frames that pass the check.
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] c;
    c = CrcInit;
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ w[i]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Mostly random words, with the two ends of the range showing up often.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One byte transfer on the input channel. The valid stays high after the
  // transfer so that back-to-back bytes never see it dropped and raised in
  // the same step; it is lowered only when an idle gap is drawn.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      src_burst = !src_burst;
    end
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Sends the first `cut` bytes of a frame of the given kind. A set bit in
  // `corrupt` spoils the check byte of that word (bit 0 first word).
  task automatic send_frame(input logic status_kind, input logic [15:0] w1,
                            input logic [15:0] w2, input logic start,
                            input logic [1:0] corrupt, input int cut);
    logic [7:0] frame_bytes[6];
    int         len;
    frame_bytes[0] = w1[15:8];
    frame_bytes[1] = w1[7:0];
    frame_bytes[2] = word_crc(w1) ^ (corrupt[0] ? 8'($urandom_range(1, 255)) : 8'h00);
    frame_bytes[3] = w2[15:8];
    frame_bytes[4] = w2[7:0];
    frame_bytes[5] = word_crc(w2) ^ (corrupt[1] ? 8'($urandom_range(1, 255)) : 8'h00);
    len = status_kind ? 3 : 6;
    if (cut < len) begin
      len = cut;
    end
    for (int i = 0; i < len; i++) begin
      send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
    end
  endtask

  // Frame kind writes happen only with the block drained: the input valid is
  // dropped, every predicted result must have been taken, and then a few
  // more cycles pass since a byte that ends no frame leaves nothing to wait on.
  task automatic write_kind(input logic k);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kind_writes++;
  endtask

  // Byte source: a short directed opening, then random phases that alternate
  // between the two frame kinds.
  initial begin : byte_source
    logic kind;
    int   sent;
    int   pick;
    int   cut;
    int   noise_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Measurement frames at reset: full-scale and zero words, a bad second
    // check, and both checks bad (the first error wins).
    send_frame(1'b0, 16'hFFFF, 16'h0000, 1'b1, 2'b00, 6);
    send_frame(1'b0, 16'h0000, 16'hFFFF, 1'b1, 2'b10, 6);
    // A stray byte, then frame start restarts the count in the middle.
    send_byte(8'hA5, 1'b1);
    send_frame(1'b0, 16'h8000, 16'h1234, 1'b1, 2'b11, 6);
    // Stop after the first group, switch to status frames, and carry on
    // without a frame start: the second-group position folds onto the first.
    send_frame(1'b0, 16'h4D2C, 16'hBEEF, 1'b1, 2'b00, 3);
    write_kind(1'b1);
    send_frame(1'b1, 16'h7FFF, 16'h0000, 1'b0, 2'b00, 3);

    kind = 1'b1;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      kind = !kind;
      write_kind(kind);
      sent = 0;
      while (sent < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // Well-formed frame, sometimes with no frame start or a bad check.
          send_frame(kind, pick_word(), pick_word(), ($urandom_range(0, 4) != 0),
                     {($urandom_range(0, 4) == 0), ($urandom_range(0, 4) == 0)}, 6);
          sent += kind ? 3 : 6;
        end else if (pick < 88) begin
          // Frame broken off early; the next one usually restarts it.
          cut = $urandom_range(1, kind ? 2 : 5);
          send_frame(kind, pick_word(), pick_word(), 1'b1, 2'b00, cut);
          sent += cut;
        end else begin
          noise_len = $urandom_range(1, 4);
          for (int i = 0; i < noise_len; i++) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
          sent += noise_len;
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d byte transfers over %0d frame kind writes, both kinds.",
             bytes_sent, kind_writes);
    $display("Compared %0d frame results, %0d of them wrong.", frames_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result sink: a random stall before each transfer, with runs of no stalls.
  // Twice it holds off for a long stretch while bytes keep coming, so the
  // block has to back up and stop taking input.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 30 || taken == 90) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) begin
        sink_burst = !sink_burst;
      end
      stall = sink_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d frame results still expected.", frames_pending);
    $display("FAIL");
    $finish;
  end

endmodule
